// ===== rtl/core/sstw_pkg.sv =====
package sstw_pkg;

    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;

    // register indexes, taken from paddr[4:2]
    localparam logic [2:0] REG_QUERY_MODE   = 3'd0;
    localparam logic [2:0] REG_QUERY_TYPE   = 3'd1;
    localparam logic [2:0] REG_QUERY_COPY   = 3'd2;
    localparam logic [2:0] REG_QUERY_HANDLE = 3'd3;
    localparam logic [2:0] REG_QUERY_NUMBER = 3'd4;
    localparam logic [2:0] REG_TABLE_LENGTH = 3'd5;

    localparam logic [1:0] MODE_TYPE_COPY = 2'd0;
    localparam logic [1:0] MODE_HANDLE    = 2'd1;
    localparam logic [1:0] MODE_NUMBER    = 2'd2;

    localparam logic KIND_REPORT  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [7:0] HDR_BYTES = 8'd4;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_AREA    = 2'd1,
        PH_STRINGS = 2'd2,
        PH_STOPPED = 2'd3
    } t_phase;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  qtype;
        logic [15:0] copy;
        logic [15:0] handle;
        logic [15:0] number;
        logic [15:0] table_length;
    } t_query;

    typedef struct packed {
        logic        kind;
        logic [15:0] offset;
        logic [15:0] index;
        logic [7:0]  rtype;
        logic [7:0]  rlength;
        logic [15:0] handle;
        logic        is_match;
        logic        found;
        logic        malformed;
        logic        last;
    } t_result;

    // everything one table byte produces: up to two results
    typedef struct packed {
        t_result first;
        t_result second;
        logic    has_second;
    } t_bundle;

endpackage

// ===== rtl/core/sstw_regs.sv =====
module sstw_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [sstw_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [sstw_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [sstw_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,
    output sstw_pkg::t_query                     o_query
);

    sstw_pkg::t_query r_query;
    logic [2:0]       reg_idx;
    logic             wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_query = r_query;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                sstw_pkg::REG_QUERY_MODE:   r_query.mode         <= pwdata[1:0];
                sstw_pkg::REG_QUERY_TYPE:   r_query.qtype        <= pwdata[7:0];
                sstw_pkg::REG_QUERY_COPY:   r_query.copy         <= pwdata[15:0];
                sstw_pkg::REG_QUERY_HANDLE: r_query.handle       <= pwdata[15:0];
                sstw_pkg::REG_QUERY_NUMBER: r_query.number       <= pwdata[15:0];
                sstw_pkg::REG_TABLE_LENGTH: r_query.table_length <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            sstw_pkg::REG_QUERY_MODE:   prdata[1:0]  = r_query.mode;
            sstw_pkg::REG_QUERY_TYPE:   prdata[7:0]  = r_query.qtype;
            sstw_pkg::REG_QUERY_COPY:   prdata[15:0] = r_query.copy;
            sstw_pkg::REG_QUERY_HANDLE: prdata[15:0] = r_query.handle;
            sstw_pkg::REG_QUERY_NUMBER: prdata[15:0] = r_query.number;
            sstw_pkg::REG_TABLE_LENGTH: prdata[15:0] = r_query.table_length;
            default: ;
        endcase
    end

endmodule

// ===== rtl/core/sstw_parser.sv =====
module sstw_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [7:0]        i_data_byte,
    input  logic              i_table_start,
    output logic              o_in_stall,
    input  sstw_pkg::t_query  i_query,
    input  logic              i_queue_full,
    output logic              o_push,
    output sstw_pkg::t_bundle o_bundle
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;

    // walk state
    logic [15:0]      r_pos, n_pos, c_pos;
    sstw_pkg::t_phase r_phase, n_phase, c_phase;
    logic [23:0]      r_hb, n_hb, c_hb;
    logic [7:0]       r_ar, n_ar, c_ar;
    logic             r_pwz, n_pwz, c_pwz;
    logic [15:0]      r_rs, n_rs, c_rs;
    logic [15:0]      r_cnt, n_cnt, c_cnt;
    logic [15:0]      r_copies, n_copies, c_copies;
    logic             r_mseen, n_mseen, c_mseen;
    logic [15:0]      r_moff, n_moff, c_moff;
    logic             r_err, n_err, c_err;

    logic             advance;
    logic             in_range;
    logic [15:0]      tl_m1;
    logic [15:0]      hdr_dist;
    logic [1:0]       hdr_k;
    logic [7:0]       hdr_type;
    logic [7:0]       hdr_len;
    logic [15:0]      hdr_handle;
    logic [7:0]       ar_dec;
    logic             m;
    logic             rep_v;
    logic             sum_v;
    sstw_pkg::t_result rep;
    sstw_pkg::t_result sum;

    assign advance    = r_in_valid && !i_queue_full;
    assign o_in_stall = r_in_valid && i_queue_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte  <= i_data_byte;
            r_in_start <= i_table_start;
        end
    end

    // a start mark restarts the walk before the byte is taken
    always_comb begin
        c_pos    = r_in_start ? '0 : r_pos;
        c_phase  = r_in_start ? sstw_pkg::PH_HEADER : r_phase;
        c_hb     = r_in_start ? '0 : r_hb;
        c_ar     = r_in_start ? '0 : r_ar;
        c_pwz    = r_in_start ? 1'b0 : r_pwz;
        c_rs     = r_in_start ? '0 : r_rs;
        c_cnt    = r_in_start ? '0 : r_cnt;
        c_copies = r_in_start ? i_query.copy : r_copies;
        c_mseen  = r_in_start ? 1'b0 : r_mseen;
        c_moff   = r_in_start ? '0 : r_moff;
        c_err    = r_in_start ? 1'b0 : r_err;
    end

    assign in_range   = c_pos < i_query.table_length;
    assign tl_m1      = i_query.table_length - 16'd1;
    assign hdr_dist   = c_pos - c_rs;
    assign hdr_k      = (hdr_dist > 16'd3) ? 2'd3 : hdr_dist[1:0];
    assign hdr_type   = c_hb[7:0];
    assign hdr_len    = c_hb[15:8];
    assign hdr_handle = {r_in_byte, c_hb[23:16]};
    assign ar_dec     = (c_ar != 8'd0) ? c_ar - 8'd1 : c_ar;

    always_comb begin
        n_pos    = c_pos;
        n_phase  = c_phase;
        n_hb     = c_hb;
        n_ar     = c_ar;
        n_pwz    = c_pwz;
        n_rs     = c_rs;
        n_cnt    = c_cnt;
        n_copies = c_copies;
        n_mseen  = c_mseen;
        n_moff   = c_moff;
        n_err    = c_err;
        m        = 1'b0;
        rep_v    = 1'b0;
        sum_v    = 1'b0;
        rep      = '0;
        sum      = '0;
        if (in_range) begin
            n_pos = c_pos + 16'd1;
            unique case (c_phase)
                sstw_pkg::PH_HEADER: begin
                    if (hdr_k == 2'd3) begin
                        if (!c_mseen) begin
                            unique case (i_query.mode)
                                sstw_pkg::MODE_TYPE_COPY: begin
                                    if (hdr_type == i_query.qtype) begin
                                        if (c_copies == 16'd0) begin
                                            m = 1'b1;
                                        end else begin
                                            n_copies = c_copies - 16'd1;
                                        end
                                    end
                                end
                                sstw_pkg::MODE_HANDLE: m = (hdr_handle == i_query.handle);
                                sstw_pkg::MODE_NUMBER: m = (c_cnt == i_query.number);
                                default:               m = 1'b0;
                            endcase
                        end
                        rep_v        = 1'b1;
                        rep.kind     = sstw_pkg::KIND_REPORT;
                        rep.offset   = c_rs;
                        rep.index    = c_cnt;
                        rep.rtype    = hdr_type;
                        rep.rlength  = hdr_len;
                        rep.handle   = hdr_handle;
                        rep.is_match = m;
                        if (m) begin
                            n_mseen = 1'b1;
                            n_moff  = c_rs;
                        end
                        if (c_cnt != 16'hFFFF) begin
                            n_cnt = c_cnt + 16'd1;
                        end
                        if (hdr_len < sstw_pkg::HDR_BYTES) begin
                            n_err   = 1'b1;
                            n_phase = sstw_pkg::PH_STOPPED;
                        end else if (hdr_len == sstw_pkg::HDR_BYTES) begin
                            n_phase = sstw_pkg::PH_STRINGS;
                            n_pwz   = 1'b0;
                        end else begin
                            n_ar    = hdr_len - sstw_pkg::HDR_BYTES;
                            n_phase = sstw_pkg::PH_AREA;
                        end
                    end else begin
                        unique case (hdr_k)
                            2'd0:    n_hb[7:0]   = r_in_byte;
                            2'd1:    n_hb[15:8]  = r_in_byte;
                            default: n_hb[23:16] = r_in_byte;
                        endcase
                    end
                end
                sstw_pkg::PH_AREA: begin
                    n_ar = ar_dec;
                    if (ar_dec == 8'd0) begin
                        n_phase = sstw_pkg::PH_STRINGS;
                        n_pwz   = 1'b0;
                    end
                end
                sstw_pkg::PH_STRINGS: begin
                    // double nul closes the string set
                    if (r_in_byte == 8'd0 && c_pwz) begin
                        n_phase = sstw_pkg::PH_HEADER;
                        n_rs    = c_pos + 16'd1;
                        n_hb    = '0;
                        n_pwz   = 1'b0;
                    end else begin
                        n_pwz = (r_in_byte == 8'd0);
                    end
                end
                default: ;
            endcase

            if (c_pos == tl_m1) begin
                // a header still open at the end of the table is truncated
                if (n_phase == sstw_pkg::PH_HEADER && n_rs <= c_pos) begin
                    n_err = 1'b1;
                end
                sum_v         = 1'b1;
                sum.kind      = sstw_pkg::KIND_SUMMARY;
                sum.offset    = n_mseen ? n_moff : 16'd0;
                sum.index     = n_cnt;
                sum.found     = n_mseen;
                sum.malformed = n_err;
                sum.last      = 1'b1;
            end
        end
    end

    always_comb begin
        o_bundle.first      = rep_v ? rep : sum;
        o_bundle.first.last = rep_v ? !sum_v : 1'b1;
        o_bundle.second     = sum;
        o_bundle.has_second = rep_v && sum_v;
    end

    assign o_push = advance && (rep_v || sum_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_phase  <= sstw_pkg::PH_HEADER;
            r_hb     <= '0;
            r_ar     <= '0;
            r_pwz    <= 1'b0;
            r_rs     <= '0;
            r_cnt    <= '0;
            r_copies <= '0;
            r_mseen  <= 1'b0;
            r_moff   <= '0;
            r_err    <= 1'b0;
        end else if (advance) begin
            r_pos    <= n_pos;
            r_phase  <= n_phase;
            r_hb     <= n_hb;
            r_ar     <= n_ar;
            r_pwz    <= n_pwz;
            r_rs     <= n_rs;
            r_cnt    <= n_cnt;
            r_copies <= n_copies;
            r_mseen  <= n_mseen;
            r_moff   <= n_moff;
            r_err    <= n_err;
        end
    end

endmodule

// ===== rtl/core/sstw_result_queue.sv =====
module sstw_result_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sstw_pkg::t_bundle i_bundle,
    output logic              o_full,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output sstw_pkg::t_result o_result
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    sstw_pkg::t_bundle r_mem [DEPTH];
    logic [PW-1:0]     r_wr, r_rd;
    logic [CW-1:0]     r_count;
    logic              r_half;
    sstw_pkg::t_bundle head;
    logic              out_take;
    logic              pop;

    assign head        = r_mem[r_rd];
    assign o_out_valid = r_count != '0;
    assign o_full      = r_count == CW'(DEPTH);
    assign o_result    = r_half ? head.second : head.first;
    assign out_take    = o_out_valid && !i_out_stall;
    // an entry leaves with its final result
    assign pop         = out_take && (r_half || !head.has_second);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
            r_half  <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && pop) begin
                r_count <= r_count - 1'b1;
            end
            if (pop) begin
                r_half <= 1'b0;
            end else if (out_take) begin
                r_half <= 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/smbios_structure_table_walker.sv =====
// Walks an SMBIOS structure table presented one byte per request and reports
// every record header as it completes, plus an end-of-table summary on the
// last table byte. One byte is taken every clock cycle while the input does
// not stall. A byte passes an input register and is parsed from it; its
// results then sit in a small queue of QUEUE_DEPTH entries until the output
// side takes them. Most bytes cause no result and some cause one; a byte
// that completes a header and also ends the table causes two, which leave
// one after the other, report first. The input stalls only while that
// queue is full, that is, when the output side holds back for longer than the
// queue covers. Registers are read live: the query in force when a header
// completes is the one applied, but the copy count is loaded at a start
// mark, and table_length bounds the walk.
module smbios_structure_table_walker #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [7:0]                           i_data_byte,
    input  logic                                 i_table_start,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_result_kind,
    output logic [15:0]                          o_record_offset,
    output logic [15:0]                          o_record_index,
    output logic [7:0]                           o_record_type,
    output logic [7:0]                           o_record_length,
    output logic [15:0]                          o_record_handle,
    output logic                                 o_is_match,
    output logic                                 o_found,
    output logic                                 o_malformed,
    output logic                                 o_last,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [sstw_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [sstw_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [sstw_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    sstw_pkg::t_query  query;
    sstw_pkg::t_bundle bundle;
    sstw_pkg::t_result result;
    logic              push;
    logic              queue_full;

    sstw_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_query (query)
    );

    sstw_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_data_byte   (i_data_byte),
        .i_table_start (i_table_start),
        .o_in_stall    (o_in_stall),
        .i_query       (query),
        .i_queue_full  (queue_full),
        .o_push        (push),
        .o_bundle      (bundle)
    );

    sstw_result_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_bundle    (bundle),
        .o_full      (queue_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (result)
    );

    assign o_result_kind   = result.kind;
    assign o_record_offset = result.offset;
    assign o_record_index  = result.index;
    assign o_record_type   = result.rtype;
    assign o_record_length = result.rlength;
    assign o_record_handle = result.handle;
    assign o_is_match      = result.is_match;
    assign o_found         = result.found;
    assign o_malformed     = result.malformed;
    assign o_last          = result.last;

endmodule

// ===== rtl/core/sstw_checker.sv =====
module sstw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_result_kind,
    input logic [15:0] o_record_offset,
    input logic [15:0] o_record_index,
    input logic [7:0]  o_record_type,
    input logic [7:0]  o_record_length,
    input logic [15:0] o_record_handle,
    input logic        o_is_match,
    input logic        o_found,
    input logic        o_malformed,
    input logic        o_last
);

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result request dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_result_kind) && $stable(o_record_offset) && $stable(o_record_index)
            && $stable(o_record_handle) && $stable(o_last))
        else $error("stalled result changed");

    a_summary_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind |-> o_last)
        else $error("summary not flagged last");

    // a report that is not last is always paired with the summary right behind it
    a_report_then_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_result_kind && !o_last
            |=> o_out_valid && o_result_kind)
        else $error("report without its summary");

    a_field_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_result_kind ? (!o_is_match && o_record_type == 8'd0 && o_record_length == 8'd0
                              && o_record_handle == 16'd0
                              && (o_found || o_record_offset == 16'd0))
                           : (!o_found && !o_malformed)))
        else $error("result fields inconsistent with kind");

endmodule

bind smbios_structure_table_walker sstw_checker u_sstw_checker (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam logic [1:0] MODE_UNDEFINED = 2'd3;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_BYTES = 900;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_table_start = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_result_kind;
    logic [15:0] o_record_offset;
    logic [15:0] o_record_index;
    logic [7:0]  o_record_type;
    logic [7:0]  o_record_length;
    logic [15:0] o_record_handle;
    logic        o_is_match;
    logic        o_found;
    logic        o_malformed;
    logic        o_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [sstw_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [sstw_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [sstw_pkg::APB_DATA_W-1:0] prdata;
    logic        pready;

    smbios_structure_table_walker DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_table_start   (i_table_start),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_result_kind   (o_result_kind),
        .o_record_offset (o_record_offset),
        .o_record_index  (o_record_index),
        .o_record_type   (o_record_type),
        .o_record_length (o_record_length),
        .o_record_handle (o_record_handle),
        .o_is_match      (o_is_match),
        .o_found         (o_found),
        .o_malformed     (o_malformed),
        .o_last          (o_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    initial begin
        #2_000_000;
        $display("smbios_structure_table_walker test failed");
        $finish;
    end

    // shadow of the query registers and of the walk
    sstw_pkg::t_query cfg;
    logic [15:0]      w_pos;
    sstw_pkg::t_phase w_phase;
    logic [31:0]      w_hdr;
    logic [7:0]       w_area;
    logic             w_prev_zero;
    logic [15:0]      w_rec_start;
    logic [15:0]      w_rec_count;
    logic [15:0]      w_copies_left;
    logic             w_match_seen;
    logic [15:0]      w_match_offset;
    logic             w_error_seen;

    sstw_pkg::t_result expected_reports[$];
    logic [7:0]  tbl[$];
    int          mismatches = 0;
    int          walked_bytes = 0;
    bit          idle_on = 1'b0;
    bit          stall_on = 1'b0;
    int          stall_left = 0;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic restart_walk();
        w_pos          = '0;
        w_phase        = sstw_pkg::PH_HEADER;
        w_hdr          = '0;
        w_area         = '0;
        w_prev_zero    = 1'b0;
        w_rec_start    = '0;
        w_rec_count    = '0;
        w_copies_left  = cfg.copy;
        w_match_seen   = 1'b0;
        w_match_offset = '0;
        w_error_seen   = 1'b0;
    endtask

    // advances the walk by one table byte and queues the reports it causes
    task automatic walk_byte(input logic [7:0] b, input logic start);
        logic [15:0]       pos;
        logic [15:0]       k;
        logic              hit;
        bit                have_rep;
        sstw_pkg::t_result rep;
        sstw_pkg::t_result sum;
        have_rep = 1'b0;
        rep = '0;
        sum = '0;
        if (start)
            restart_walk();
        pos = w_pos;
        if (pos >= cfg.table_length)
            return;
        walked_bytes++;
        case (w_phase)
            sstw_pkg::PH_HEADER: begin
                k = pos - w_rec_start;
                if (k > 16'd3)
                    k = 16'd3;
                w_hdr[8*k[1:0] +: 8] = b;
                if (k == 16'd3) begin
                    hit = 1'b0;
                    if (!w_match_seen) begin
                        case (cfg.mode)
                            sstw_pkg::MODE_TYPE_COPY: begin
                                if (w_hdr[7:0] == cfg.qtype) begin
                                    if (w_copies_left == 16'd0)
                                        hit = 1'b1;
                                    else
                                        w_copies_left = w_copies_left - 16'd1;
                                end
                            end
                            sstw_pkg::MODE_HANDLE: hit = (w_hdr[31:16] == cfg.handle);
                            sstw_pkg::MODE_NUMBER: hit = (w_rec_count == cfg.number);
                            default:               hit = 1'b0;
                        endcase
                    end
                    rep.kind     = sstw_pkg::KIND_REPORT;
                    rep.offset   = w_rec_start;
                    rep.index    = w_rec_count;
                    rep.rtype    = w_hdr[7:0];
                    rep.rlength  = w_hdr[15:8];
                    rep.handle   = w_hdr[31:16];
                    rep.is_match = hit;
                    have_rep     = 1'b1;
                    if (hit) begin
                        w_match_seen   = 1'b1;
                        w_match_offset = w_rec_start;
                    end
                    if (w_rec_count != 16'hFFFF)
                        w_rec_count = w_rec_count + 16'd1;
                    if (w_hdr[15:8] < sstw_pkg::HDR_BYTES) begin
                        w_error_seen = 1'b1;
                        w_phase = sstw_pkg::PH_STOPPED;
                    end else if (w_hdr[15:8] == sstw_pkg::HDR_BYTES) begin
                        w_phase = sstw_pkg::PH_STRINGS;
                        w_prev_zero = 1'b0;
                    end else begin
                        w_area = w_hdr[15:8] - sstw_pkg::HDR_BYTES;
                        w_phase = sstw_pkg::PH_AREA;
                    end
                end
            end
            sstw_pkg::PH_AREA: begin
                if (w_area != 8'd0)
                    w_area = w_area - 8'd1;
                if (w_area == 8'd0) begin
                    w_phase = sstw_pkg::PH_STRINGS;
                    w_prev_zero = 1'b0;
                end
            end
            sstw_pkg::PH_STRINGS: begin
                // a double nul closes the string set
                if (b == 8'h00 && w_prev_zero) begin
                    w_phase = sstw_pkg::PH_HEADER;
                    w_rec_start = pos + 16'd1;
                    w_hdr = '0;
                    w_prev_zero = 1'b0;
                end else begin
                    w_prev_zero = (b == 8'h00);
                end
            end
            default: ;
        endcase
        w_pos = pos + 16'd1;

        if (pos == 16'(cfg.table_length - 16'd1)) begin
            if (w_phase == sstw_pkg::PH_HEADER && w_rec_start <= pos)
                w_error_seen = 1'b1;
            sum.kind      = sstw_pkg::KIND_SUMMARY;
            sum.offset    = w_match_seen ? w_match_offset : 16'd0;
            sum.index     = w_rec_count;
            sum.found     = w_match_seen;
            sum.malformed = w_error_seen;
            sum.last      = 1'b1;
            if (have_rep)
                expected_reports.push_back(rep);
            expected_reports.push_back(sum);
        end else if (have_rep) begin
            rep.last = 1'b1;
            expected_reports.push_back(rep);
        end
    endtask

    // output side: random stalls, mostly short, now and then long
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (stall_on && $urandom_range(0, 99) < 25) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 40))
                                                      : int'($urandom_range(0, 2));
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        sstw_pkg::t_result got;
        sstw_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.kind      = o_result_kind;
            got.offset    = o_record_offset;
            got.index     = o_record_index;
            got.rtype     = o_record_type;
            got.rlength   = o_record_length;
            got.handle    = o_record_handle;
            got.is_match  = o_is_match;
            got.found     = o_found;
            got.malformed = o_malformed;
            got.last      = o_last;
            if (expected_reports.size() == 0) begin
                report_mismatch("unexpected result, offset", 32'(got.offset), 32'd0);
            end else begin
                want = expected_reports.pop_front();
                if (got.kind != want.kind)
                    report_mismatch("result_kind", 32'(got.kind), 32'(want.kind));
                if (got.offset != want.offset)
                    report_mismatch("record_offset", 32'(got.offset), 32'(want.offset));
                if (got.index != want.index)
                    report_mismatch("record_index", 32'(got.index), 32'(want.index));
                if (got.rtype != want.rtype)
                    report_mismatch("record_type", 32'(got.rtype), 32'(want.rtype));
                if (got.rlength != want.rlength)
                    report_mismatch("record_length", 32'(got.rlength), 32'(want.rlength));
                if (got.handle != want.handle)
                    report_mismatch("record_handle", 32'(got.handle), 32'(want.handle));
                if (got.is_match != want.is_match)
                    report_mismatch("is_match", 32'(got.is_match), 32'(want.is_match));
                if (got.found != want.found)
                    report_mismatch("found", 32'(got.found), 32'(want.found));
                if (got.malformed != want.malformed)
                    report_mismatch("malformed", 32'(got.malformed), 32'(want.malformed));
                if (got.last != want.last)
                    report_mismatch("last", 32'(got.last), 32'(want.last));
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            sstw_pkg::REG_QUERY_MODE:   cfg.mode = val[1:0];
            sstw_pkg::REG_QUERY_TYPE:   cfg.qtype = val[7:0];
            sstw_pkg::REG_QUERY_COPY:   cfg.copy = val[15:0];
            sstw_pkg::REG_QUERY_HANDLE: cfg.handle = val[15:0];
            sstw_pkg::REG_QUERY_NUMBER: cfg.number = val[15:0];
            sstw_pkg::REG_TABLE_LENGTH: cfg.table_length = val[15:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // the block may still hold a byte that makes no report, so keep clocking after the last expected result
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure_walk(input logic [1:0] mode, input logic [7:0] qtype,
                                  input logic [15:0] copy, input logic [15:0] handle,
                                  input logic [15:0] number, input logic [15:0] tlen);
        wait_idle();
        write_reg(sstw_pkg::REG_QUERY_MODE, 32'(mode));
        write_reg(sstw_pkg::REG_QUERY_TYPE, 32'(qtype));
        write_reg(sstw_pkg::REG_QUERY_COPY, 32'(copy));
        write_reg(sstw_pkg::REG_QUERY_HANDLE, 32'(handle));
        write_reg(sstw_pkg::REG_QUERY_NUMBER, 32'(number));
        write_reg(sstw_pkg::REG_TABLE_LENGTH, 32'(tlen));
    endtask

    task automatic send_byte(input logic [7:0] b, input logic start);
        int gap;
        gap = 0;
        if (idle_on) begin
            case ($urandom_range(0, 24))
                0, 1:          gap = int'($urandom_range(8, 30));
                2, 3, 4, 5, 6: gap = int'($urandom_range(1, 3));
                default:       gap = 0;
            endcase
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_data_byte   <= b;
        i_table_start <= start;
        do @(posedge i_clk); while (o_in_stall);
        walk_byte(b, start);
    endtask

    task automatic send_table(input logic start);
        for (int i = 0; i < tbl.size(); i++)
            send_byte(tbl[i], start && (i == 0));
        tbl.delete();
    endtask

    task automatic add_header(input logic [7:0] rtype, input logic [7:0] rlen,
                              input logic [15:0] handle);
        tbl.push_back(rtype);
        tbl.push_back(rlen);
        tbl.push_back(handle[7:0]);
        tbl.push_back(handle[15:8]);
    endtask

    task automatic add_record(input logic [7:0] rtype, input logic [7:0] rlen,
                              input logic [15:0] handle, input int nstr);
        add_header(rtype, rlen, handle);
        if (rlen > sstw_pkg::HDR_BYTES)
            repeat (rlen - sstw_pkg::HDR_BYTES) tbl.push_back(8'($urandom_range(0, 255)));
        for (int s = 0; s < nstr; s++) begin
            repeat ($urandom_range(1, 4)) tbl.push_back(8'($urandom_range(1, 255)));
            tbl.push_back(8'h00);
        end
        if (nstr == 0)
            tbl.push_back(8'h00);
        tbl.push_back(8'h00);
    endtask

    // bytes after reset count as a walk even without a start mark;
    // the last header byte also ends the table, giving a report and a summary
    task automatic test_walk_without_start();
        add_record(8'h11, sstw_pkg::HDR_BYTES, 16'h1234, 0);
        add_header(8'h11, 8'h06, 16'h5678);
        configure_walk(sstw_pkg::MODE_TYPE_COPY, 8'h11, 16'd2, 16'h0000, 16'h0000,
                       16'(tbl.size()));
        send_table(1'b0);
    endtask

    task automatic test_length_below_four();
        add_header(8'hFF, 8'h02, 16'hFFFF);
        tbl.push_back(8'hFF);
        configure_walk(sstw_pkg::MODE_HANDLE, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                       16'(tbl.size()));
        send_table(1'b1);
    endtask

    task automatic test_truncated_header();
        add_record(8'h00, sstw_pkg::HDR_BYTES, 16'h0000, 0);
        tbl.push_back(8'h00);
        tbl.push_back(8'h08);
        configure_walk(MODE_UNDEFINED, 8'h00, 16'h0000, 16'h0000, 16'h0000,
                       16'(tbl.size()));
        send_table(1'b1);
    endtask

    // formatted area still open at the end, then one byte past the table
    task automatic test_open_area_and_past_table();
        add_header(8'h7E, 8'hFF, 16'h8001);
        tbl.push_back(8'hA5);
        configure_walk(sstw_pkg::MODE_NUMBER, 8'h7E, 16'h0001, 16'h8001, 16'h0000,
                       16'(tbl.size()));
        tbl.push_back(8'h5A);
        send_table(1'b1);
    endtask

    task automatic test_zero_length_table();
        tbl.push_back(8'h01);
        configure_walk(sstw_pkg::MODE_TYPE_COPY, 8'h01, 16'h0000, 16'h0000, 16'h0000,
                       16'd0);
        send_table(1'b1);
    endtask

    task automatic test_random_tables();
        logic [1:0]  mode;
        logic [7:0]  qtype;
        logic [15:0] copy;
        logic [15:0] handle;
        logic [15:0] number;
        logic [15:0] tlen;
        logic [7:0]  rtype;
        logic [7:0]  rlen;
        logic [15:0] rhandle;
        int          shape;
        int          sel;
        walked_bytes = 0;
        while (walked_bytes < RANDOM_BYTES) begin
            idle_on  = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            sel = $urandom_range(0, 15);
            mode = (sel < 5) ? sstw_pkg::MODE_TYPE_COPY : (sel < 10) ? sstw_pkg::MODE_HANDLE :
                   (sel < 15) ? sstw_pkg::MODE_NUMBER : MODE_UNDEFINED;
            qtype  = ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom_range(0, 3));
            copy   = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 2));
            handle = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 7));
            number = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 5));

            repeat ($urandom_range(1, 4)) begin
                case ($urandom_range(0, 7))
                    0:       rtype = 8'hFF;
                    1:       rtype = 8'($urandom_range(0, 255));
                    default: rtype = 8'($urandom_range(0, 3));
                endcase
                sel = $urandom_range(0, 49);
                rlen = (sel == 0) ? 8'hFF : (sel < 4) ? 8'($urandom_range(0, 3))
                                                      : 8'($urandom_range(4, 10));
                case ($urandom_range(0, 7))
                    0:       rhandle = 16'hFFFF;
                    1:       rhandle = 16'($urandom_range(0, 65535));
                    default: rhandle = 16'($urandom_range(0, 7));
                endcase
                add_record(rtype, rlen, rhandle, int'($urandom_range(0, 2)));
            end

            shape = $urandom_range(0, 39);
            tlen = 16'(tbl.size());
            if (shape < 4) begin
                // cut anywhere: header, area or strings may be left open
                tlen = 16'($urandom_range(1, tbl.size()));
            end else if (shape < 7) begin
                tbl.delete();
                repeat ($urandom_range(1, 20)) tbl.push_back(8'($urandom_range(0, 255)));
                tlen = 16'(tbl.size());
            end else if (shape == 7) begin
                tlen = 16'hFFFF;
            end
            configure_walk(mode, qtype, copy, handle, number, tlen);
            if (shape >= 8 && shape < 11)
                repeat ($urandom_range(1, 4)) tbl.push_back(8'($urandom_range(0, 255)));
            send_table($urandom_range(0, 19) != 0);
        end
    endtask

    initial begin
        int wait_cycles;
        cfg = '0;
        restart_walk();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_walk_without_start();
        test_length_below_four();
        test_truncated_header();
        test_open_area_and_past_table();
        test_zero_length_table();
        test_random_tables();

        i_in_valid <= 1'b0;
        for (wait_cycles = 0; wait_cycles < 5000 && expected_reports.size() != 0;
             wait_cycles++)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_reports.size() != 0)
            report_mismatch("results still outstanding", 32'(expected_reports.size()), 32'd0);

        if (mismatches == 0)
            $display("smbios_structure_table_walker test passed");
        else
            $display("smbios_structure_table_walker test failed");
        $finish;
    end

endmodule
